>>> hdl/assert_macros.svh
// assertion helpers shared by the timer pool modules
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define STP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define STP_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

>>> hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and helpers of the software timer pool.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int NUM_TIMERS = 64;
  localparam int SLOT_W     = $clog2(NUM_TIMERS);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int GEN_W      = 8;
  localparam int HANDLE_W   = 14;
  localparam int CNT_W      = 32;
  localparam int TICKS_W    = 31;
  localparam int REQ_W      = 3;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;

  localparam logic [PTR_W-1:0] NONE_PTR    = PTR_W'(NUM_TIMERS);
  localparam logic [7:0]       MAX_INT_RST = 8'd10;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RELOAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd6;

  typedef enum logic [2:0] {
    OP_START, OP_STOP, OP_SET, OP_RELOAD, OP_PAUSE, OP_TICK, OP_READ
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic               hzero;
    logic [15:0]        message;
    logic [15:0]        receiver;
    logic [TICKS_W-1:0] ticks;
    logic               periodic;
    logic               pause;
    logic [7:0]         elapsed;
  } cmd_t;

  // back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } stat_t;

  // one timer slot record
  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic [TICKS_W-1:0]      reload;
    logic [15:0]             message;
    logic [15:0]             receiver;
    logic                    periodic;
    logic                    paused;
    logic [GEN_W-1:0]        gen;
    logic                    in_use;
  } rec_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_MOD, S_READ, S_STOP_CHK, S_WALK, S_WALK_NX,
    S_RELRD, S_REL1, S_REL2, S_REL3, S_TICK_ISS, S_TICK_EV, S_TICK_END,
    S_DRN_ISS, S_DRN_OUT
  } bst_t;

  // generation advance, skipping zero
  function automatic logic [GEN_W-1:0] gen_inc(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    if (n == '0) n = GEN_W'(1);
    return n;
  endfunction

  // handle of a slot: generation above slot index
  function automatic logic [HANDLE_W-1:0] handle_of(input logic [GEN_W-1:0] g,
                                                    input logic [SLOT_W-1:0] s);
    return HANDLE_W'({g, s});
  endfunction

endpackage

>>> hdl/stp_front.sv
// ----------------------------------------------------------------------------
// stp_front
// Accepts request transactions, decodes them and drops requests with no effect.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_front
  import stp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [REQ_W-1:0]     in_tuser,
  input  logic                 q_full,
  input  stat_t                stat,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic                accept;
  logic [HANDLE_W-1:0] handle;
  logic                drop;
  logic                seen_r;

  assign in_tready = !q_full && !stat.clearing;
  assign accept    = in_tvalid && in_tready;
  assign handle    = in_tdata[13:0];

  // field unpack
  always_comb begin
    q_cmd.slot     = handle[SLOT_W-1:0];
    q_cmd.hzero    = (handle == '0);
    q_cmd.message  = in_tdata[29:14];
    q_cmd.receiver = in_tdata[45:30];
    q_cmd.ticks    = in_tdata[76:46];
    q_cmd.periodic = in_tdata[77];
    q_cmd.pause    = in_tdata[78];
    q_cmd.elapsed  = in_tdata[86:79];
  end

  // request classification
  always_comb begin
    drop     = 1'b0;
    q_cmd.op = OP_START;
    unique case (in_tuser)
      REQ_START:  q_cmd.op = OP_START;
      REQ_STOP:   begin q_cmd.op = OP_STOP;   drop = q_cmd.hzero; end
      REQ_SET:    begin q_cmd.op = OP_SET;    drop = q_cmd.hzero; end
      REQ_RELOAD: begin q_cmd.op = OP_RELOAD; drop = q_cmd.hzero; end
      REQ_PAUSE:  begin q_cmd.op = OP_PAUSE;  drop = q_cmd.hzero; end
      REQ_TICK:   q_cmd.op = OP_TICK;
      REQ_READ:   q_cmd.op = OP_READ;
      default:    drop = 1'b1;
    endcase
  end

  assign q_push = accept && !drop;

  // tracks that the first transaction came in, for checking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (accept) begin
      seen_r <= 1'b1;
    end
  end

  `STP_IMPLY(a_no_accept_in_clear, stat.clearing, !in_tready, "ready during clear")
  `STP_IMPLY(a_push_needs_accept, q_push, accept && seen_r == seen_r, "push without accept")
  `STP_IMPLY(a_no_push_full, q_full, !q_push, "push into full queue")

endmodule

>>> hdl/stp_queue.sv
// ----------------------------------------------------------------------------
// stp_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_queue
  import stp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  `STP_IMPLY(a_pop_nonempty, pop, valid, "pop from empty queue")
  `STP_ASSERT(a_cnt_range, cnt_r != 2'd3, "queue count out of range")
  `STP_IMPLY(a_ptr_match, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r, "pointer mismatch")

endmodule

>>> hdl/stp_back.sv
// ----------------------------------------------------------------------------
// stp_back
// Executes timer commands against the slot memories and drives results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_back
  import stp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output stat_t                 stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [15:0]         message;
    logic [15:0]         receiver;
  } exp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]     reply_handle;
    logic signed [CNT_W-1:0] remaining;
    logic                    exp_valid;
    logic [HANDLE_W-1:0]     exp_handle;
    logic [15:0]             exp_message;
    logic [15:0]             exp_receiver;
    logic [7:0]              next_interval;
    logic                    last;
  } res_t;

  // slot memories and expiry buffer
  rec_t             rec_mem [NUM_TIMERS];
  logic [PTR_W-1:0] lnk_mem [NUM_TIMERS];
  exp_t             exp_mem [NUM_TIMERS];

  rec_t             rec_rd;
  logic [PTR_W-1:0] lnk_rd;
  exp_t             exp_rd;

  logic              rec_we, lnk_we, exp_we;
  logic [SLOT_W-1:0] rd_addr, rec_wa, lnk_wa, exp_wa, exp_ra;
  rec_t              rec_wd;
  logic [PTR_W-1:0]  lnk_wd;
  exp_t              exp_wd;

  bst_t             state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, nxt_r, nxt_nxt;
  logic [PTR_W-1:0] free_head_r, free_head_nxt, free_tail_r, free_tail_nxt;
  logic [PTR_W-1:0] active_head_r, active_head_nxt;
  logic [PTR_W-1:0] lnk_q_r, lnk_q_nxt;
  rec_t             rec_q_r, rec_q_nxt;
  logic [PTR_W-1:0] n_r, n_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [7:0]       hint_r, hint_nxt, max_r, max_nxt;
  logic             ret_tick_r, ret_tick_nxt;
  logic [PTR_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  logic                    out_free;
  logic                    emit;
  res_t                    res;
  logic signed [CNT_W-1:0] cnt, after;
  logic                    expd;
  rec_t                    upd;

  assign out_free = !out_valid_r || out_tready;
  assign stat.clearing = (state_r == S_CLEAR);
  assign exp_ra = k_r;

  // tick arithmetic on the record just read
  always_comb begin
    cnt   = rec_rd.paused ? rec_rd.count
                          : rec_rd.count - $signed({24'd0, cmd_r.elapsed});
    expd  = (cnt <= $signed(32'sd0));
    after = (expd && rec_rd.periodic) ? $signed({1'b0, rec_rd.reload}) : cnt;
    upd       = rec_rd;
    upd.count = after;
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    s_nxt           = s_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    nxt_nxt         = nxt_r;
    free_head_nxt   = free_head_r;
    free_tail_nxt   = free_tail_r;
    active_head_nxt = active_head_r;
    lnk_q_nxt       = lnk_q_r;
    rec_q_nxt       = rec_q_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    hint_nxt        = hint_r;
    ret_tick_nxt    = ret_tick_r;
    clr_nxt         = clr_r;
    max_nxt         = cfg_we ? cfg_wdata : max_r;
    q_pop           = 1'b0;
    rd_addr         = cur_r[SLOT_W-1:0];
    rec_we = 1'b0; rec_wa = s_r; rec_wd = rec_q_r;
    lnk_we = 1'b0; lnk_wa = s_r; lnk_wd = NONE_PTR;
    exp_we = 1'b0; exp_wa = n_r[SLOT_W-1:0]; exp_wd = '0;
    emit = 1'b0;
    res  = '0;

    unique case (state_r)
      // reset pass over the slot memories
      S_CLEAR: begin
        rec_we = 1'b1;
        rec_wa = clr_r[SLOT_W-1:0];
        rec_wd = '0;
        rec_wd.gen = GEN_W'(1);
        lnk_we = 1'b1;
        lnk_wa = clr_r[SLOT_W-1:0];
        lnk_wd = clr_r + PTR_W'(1);
        clr_nxt = clr_r + PTR_W'(1);
        if (clr_r == NONE_PTR - PTR_W'(1)) state_nxt = S_IDLE;
      end
      // take the next command
      S_IDLE: begin
        rd_addr = (q_cmd.op == OP_START) ? free_head_r[SLOT_W-1:0] : q_cmd.slot;
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          s_nxt   = q_cmd.slot;
          unique case (q_cmd.op)
            OP_START:  state_nxt = S_START;
            OP_SET, OP_RELOAD, OP_PAUSE: state_nxt = S_MOD;
            OP_READ:   state_nxt = S_READ;
            OP_STOP:   state_nxt = S_STOP_CHK;
            OP_TICK: begin
              cur_nxt   = active_head_r;
              prev_nxt  = NONE_PTR;
              n_nxt     = '0;
              hint_nxt  = max_r;
              state_nxt = S_TICK_ISS;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // start: pop free head, push onto active list
      S_START: begin
        rd_addr = free_head_r[SLOT_W-1:0];
        if (out_free) begin
          emit = 1'b1;
          res.last = 1'b1;
          state_nxt = S_IDLE;
          if (free_head_r != NONE_PTR) begin
            rec_we = 1'b1;
            rec_wa = free_head_r[SLOT_W-1:0];
            rec_wd.count    = $signed({1'b0, cmd_r.ticks});
            rec_wd.reload   = cmd_r.ticks;
            rec_wd.message  = cmd_r.message;
            rec_wd.receiver = cmd_r.receiver;
            rec_wd.periodic = cmd_r.periodic;
            rec_wd.paused   = 1'b0;
            rec_wd.gen      = rec_rd.gen;
            rec_wd.in_use   = 1'b1;
            lnk_we = 1'b1;
            lnk_wa = free_head_r[SLOT_W-1:0];
            lnk_wd = active_head_r;
            active_head_nxt  = free_head_r;
            free_head_nxt    = lnk_rd;
            res.reply_handle = handle_of(rec_rd.gen, free_head_r[SLOT_W-1:0]);
          end
        end
      end
      // set, reload, pause: read-modify-write of one record
      S_MOD: begin
        rd_addr = s_r;
        rec_we  = 1'b1;
        rec_wd  = rec_rd;
        priority case (cmd_r.op)
          OP_SET: begin
            rec_wd.reload = cmd_r.ticks;
            rec_wd.count  = $signed({1'b0, cmd_r.ticks});
          end
          OP_RELOAD: rec_wd.count = $signed({1'b0, rec_rd.reload});
          default:   rec_wd.paused = cmd_r.pause;
        endcase
        state_nxt = S_IDLE;
      end
      S_READ: begin
        rd_addr = s_r;
        if (out_free) begin
          emit = 1'b1;
          res.last = 1'b1;
          res.remaining = cmd_r.hzero ? '0 : rec_rd.count;
          state_nxt = S_IDLE;
        end
      end
      // stop: only slots in use are searched for
      S_STOP_CHK: begin
        rd_addr = s_r;
        ret_tick_nxt = 1'b0;
        if (rec_rd.in_use) begin
          cur_nxt   = active_head_r;
          prev_nxt  = NONE_PTR;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (cur_r == NONE_PTR) state_nxt = S_IDLE;
        else if (cur_r[SLOT_W-1:0] == s_r) state_nxt = S_RELRD;
        else state_nxt = S_WALK_NX;
      end
      S_WALK_NX: begin
        prev_nxt  = cur_r;
        cur_nxt   = lnk_rd;
        state_nxt = S_WALK;
      end
      S_RELRD: begin
        rec_q_nxt = rec_rd;
        lnk_q_nxt = lnk_rd;
        state_nxt = S_REL1;
      end
      // release: unlink from active list, free the record
      S_REL1: begin
        if (prev_r == NONE_PTR) begin
          active_head_nxt = lnk_q_r;
        end else begin
          lnk_we = 1'b1;
          lnk_wa = prev_r[SLOT_W-1:0];
          lnk_wd = lnk_q_r;
        end
        rec_we = 1'b1;
        rec_wd.in_use = 1'b0;
        rec_wd.gen    = gen_inc(rec_q_r.gen);
        state_nxt = S_REL2;
      end
      S_REL2: begin
        lnk_we = 1'b1;
        lnk_wd = NONE_PTR;
        state_nxt = S_REL3;
      end
      // release: append to the free tail
      S_REL3: begin
        if (free_head_r == NONE_PTR) begin
          free_head_nxt = {1'b0, s_r};
        end else begin
          lnk_we = 1'b1;
          lnk_wa = free_tail_r[SLOT_W-1:0];
          lnk_wd = {1'b0, s_r};
        end
        free_tail_nxt = {1'b0, s_r};
        if (ret_tick_r) begin
          cur_nxt   = nxt_r;
          state_nxt = S_TICK_ISS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // tick walk over the active list
      S_TICK_ISS: begin
        state_nxt = (cur_r == NONE_PTR) ? S_TICK_END : S_TICK_EV;
      end
      S_TICK_EV: begin
        nxt_nxt = lnk_rd;
        if (expd) begin
          exp_we = 1'b1;
          exp_wd.handle   = handle_of(rec_rd.gen, cur_r[SLOT_W-1:0]);
          exp_wd.message  = rec_rd.message;
          exp_wd.receiver = rec_rd.receiver;
          n_nxt = n_r + PTR_W'(1);
        end
        if (expd && !rec_rd.periodic) begin
          s_nxt        = cur_r[SLOT_W-1:0];
          rec_q_nxt    = upd;
          lnk_q_nxt    = lnk_rd;
          ret_tick_nxt = 1'b1;
          state_nxt    = S_REL1;
        end else begin
          rec_we = 1'b1;
          rec_wa = cur_r[SLOT_W-1:0];
          rec_wd = upd;
          if (after > $signed(32'sd0) && after < $signed({24'd0, hint_r}))
            hint_nxt = after[7:0];
          prev_nxt  = cur_r;
          cur_nxt   = lnk_rd;
          state_nxt = S_TICK_ISS;
        end
      end
      S_TICK_END: begin
        if (n_r == '0) begin
          if (out_free) begin
            emit = 1'b1;
            res.next_interval = hint_r;
            res.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          k_nxt     = '0;
          state_nxt = S_DRN_ISS;
        end
      end
      // replay buffered expiries with the final hint
      S_DRN_ISS: state_nxt = S_DRN_OUT;
      S_DRN_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          res.exp_valid     = 1'b1;
          res.exp_handle    = exp_rd.handle;
          res.exp_message   = exp_rd.message;
          res.exp_receiver  = exp_rd.receiver;
          res.next_interval = hint_r;
          res.last = ({1'b0, k_r} == n_r - PTR_W'(1));
          if (res.last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + SLOT_W'(1);
            state_nxt = S_DRN_ISS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit || (out_valid_r && !out_tready);
    out_res_nxt   = emit ? res : out_res_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      free_head_r   <= '0;
      free_tail_r   <= NONE_PTR - PTR_W'(1);
      active_head_r <= NONE_PTR;
      max_r         <= MAX_INT_RST;
      out_valid_r   <= 1'b0;
      n_r           <= '0;
      ret_tick_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      free_head_r   <= free_head_nxt;
      free_tail_r   <= free_tail_nxt;
      active_head_r <= active_head_nxt;
      max_r         <= max_nxt;
      out_valid_r   <= out_valid_nxt;
      n_r           <= n_nxt;
      ret_tick_r    <= ret_tick_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    s_r       <= s_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    nxt_r     <= nxt_nxt;
    lnk_q_r   <= lnk_q_nxt;
    rec_q_r   <= rec_q_nxt;
    k_r       <= k_nxt;
    hint_r    <= hint_nxt;
    out_res_r <= out_res_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (exp_we) exp_mem[exp_wa] <= exp_wd;
    rec_rd <= rec_mem[rd_addr];
    lnk_rd <= lnk_mem[rd_addr];
    exp_rd <= exp_mem[exp_ra];
  end

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.exp_valid;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {4'd0, out_res_r.next_interval, out_res_r.exp_receiver,
                       out_res_r.exp_message, out_res_r.exp_handle,
                       out_res_r.remaining, out_res_r.reply_handle};

  `STP_ASSERT(a_heads_differ, free_head_r != active_head_r || free_head_r == NONE_PTR, "free and active heads collide")
  `STP_ASSERT(a_exp_count, n_r <= NONE_PTR, "expiry count beyond pool size")
  `STP_IMPLY(a_clear_quiet, state_r == S_CLEAR, !out_valid_r && !q_pop, "activity during clear")

endmodule

>>> hdl/software_timer_pool.sv
// ----------------------------------------------------------------------------
// software_timer_pool
// Pool of 64 timer slots with start, stop, set, reload, pause, tick and read.
// ----------------------------------------------------------------------------
// Requests enter on in_* (request code in in_tuser), results leave on out_*
// (expiry flag in out_tuser, tlast on the final result of a request).
// max_interval is written through cfg_we / cfg_wdata; the user must write
// it only while the pool is idle, which the block does not enforce. After
// reset a clearing pass initializes the slot memories; in_tready stays low
// during it. A decode stage feeds a two-entry queue; the execution unit
// pulls from it. In the execution unit, stop walks the active list up to
// the target and then releases it; tick walks every active timer, frees
// expired one-shots and then replays each buffered expiry as a result.
// Results sit in one output register; while it is full and out_tready is
// low, the unit holds at its next result, and new requests keep entering
// until the queue is full.
// ----------------------------------------------------------------------------
module software_timer_pool
  import stp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,   // max_interval
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // timer_handle, message, receiver, ticks, periodic, pause, elapsed, pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [REQ_W-1:0]      in_tuser,    // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // reply_handle, remaining_ticks, expiry_handle, expiry_message,
  // expiry_receiver, next_interval, pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,   // expiry_valid
  output logic                  out_tlast    // last
);

  logic  q_push, q_full, q_valid, q_pop;
  cmd_t  push_cmd, head_cmd;
  stat_t stat;

  stp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .stat      (stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  stp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd),
    .pop      (q_pop)
  );

  stp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/software_timer_pool_tb.sv
// ----------------------------------------------------------------------------
// software_timer_pool_tb
// Self-checking bench for the timer pool: a queue-fed driver pushes requests,
// a behavioral pool model predicts replies and expiries, and a monitor checks
// every result transaction in order. Idle and stall rates change per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module software_timer_pool_tb;
  import stp_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  SETTLE       = 400;
  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(NUM_TIMERS);

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [HANDLE_W-1:0] handle;
    logic [15:0]         message;
    logic [15:0]         receiver;
    logic [TICKS_W-1:0]  ticks;
    logic                periodic;
    logic                pause;
    logic [7:0]          elapsed;
  } timer_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] reply_handle;
    logic [31:0]         remaining;
    logic                exp_valid;
    logic [HANDLE_W-1:0] exp_handle;
    logic [15:0]         exp_message;
    logic [15:0]         exp_receiver;
    logic [7:0]          next_interval;
    logic                last;
  } timer_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [7:0]            cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  software_timer_pool dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // pool model state
  longint           pm_count [NUM_TIMERS];
  logic [TICKS_W-1:0] pm_reload [NUM_TIMERS];
  logic [15:0]      pm_message [NUM_TIMERS];
  logic [15:0]      pm_receiver [NUM_TIMERS];
  logic             pm_periodic [NUM_TIMERS];
  logic             pm_paused [NUM_TIMERS];
  logic [GEN_W-1:0] pm_gen [NUM_TIMERS];
  logic             pm_in_use [NUM_TIMERS];
  logic [PTR_W-1:0] pm_link [NUM_TIMERS];
  logic [PTR_W-1:0] pm_free_head, pm_free_tail, pm_active_head;
  logic [7:0]       pm_max_interval;

  timer_req_t pending_reqs[$];
  timer_res_t expected_results[$];
  timer_req_t drv_req;
  int idle_in, idle_out;
  int errors;
  int cycle_cnt;

  function automatic logic [HANDLE_W-1:0] slot_handle(int s);
    return HANDLE_W'({pm_gen[s], SLOT_W'(s)});
  endfunction

  // unlink from the active list and append to the free tail
  function automatic void free_slot(int s, logic [PTR_W-1:0] prv);
    if (prv == NO_SLOT) pm_active_head = pm_link[s];
    else pm_link[prv] = pm_link[s];
    pm_link[s] = NO_SLOT;
    if (pm_free_head == NO_SLOT) pm_free_head = PTR_W'(s);
    else pm_link[pm_free_tail] = PTR_W'(s);
    pm_free_tail = PTR_W'(s);
    pm_in_use[s] = 1'b0;
    pm_gen[s] = pm_gen[s] + 1'b1;
    if (pm_gen[s] == '0) pm_gen[s] = 1;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      pm_count[i] = 0; pm_reload[i] = '0; pm_message[i] = '0; pm_receiver[i] = '0;
      pm_periodic[i] = 0; pm_paused[i] = 0; pm_gen[i] = 1; pm_in_use[i] = 0;
      pm_link[i] = PTR_W'(i + 1);
    end
    pm_free_head = '0;
    pm_free_tail = PTR_W'(NUM_TIMERS - 1);
    pm_active_head = NO_SLOT;
    pm_max_interval = MAX_INT_RST;
  endfunction

  // apply one accepted request to the model, queue the results it causes
  function automatic void predict_request(timer_req_t r);
    timer_res_t res;
    timer_res_t tick_res[$];
    int s;
    logic [PTR_W-1:0] cur, prv, nxt;
    int steps;
    logic freed;
    longint hint;
    s = int'(r.handle) % NUM_TIMERS;
    res = '0;
    case (r.req)
      REQ_START: begin
        res.last = 1'b1;
        if (pm_free_head != NO_SLOT) begin
          s = int'(pm_free_head);
          pm_free_head = pm_link[s];
          pm_receiver[s] = r.receiver;
          pm_message[s] = r.message;
          pm_paused[s] = 0;
          pm_reload[s] = r.ticks;
          pm_count[s] = longint'(r.ticks);
          pm_periodic[s] = r.periodic;
          pm_in_use[s] = 1;
          pm_link[s] = pm_active_head;
          pm_active_head = PTR_W'(s);
          res.reply_handle = slot_handle(s);
        end
        expected_results.push_back(res);
      end
      REQ_TICK: begin
        hint = longint'(pm_max_interval);
        cur = pm_active_head;
        prv = NO_SLOT;
        steps = 0;
        while (cur != NO_SLOT && steps < NUM_TIMERS) begin
          nxt = pm_link[cur];
          freed = 0;
          steps++;
          if (!pm_paused[cur]) pm_count[cur] -= longint'(r.elapsed);
          if (pm_count[cur] <= 0) begin
            res = '0;
            res.exp_valid = 1'b1;
            res.exp_handle = slot_handle(cur);
            res.exp_message = pm_message[cur];
            res.exp_receiver = pm_receiver[cur];
            tick_res.push_back(res);
            if (pm_periodic[cur]) pm_count[cur] = longint'(pm_reload[cur]);
            else begin
              free_slot(cur, prv);
              freed = 1;
            end
          end
          if (pm_count[cur] > 0 && pm_count[cur] < hint) hint = pm_count[cur];
          if (!freed) prv = cur;
          cur = nxt;
        end
        if (tick_res.size() == 0) tick_res.push_back('0);
        foreach (tick_res[k]) begin
          tick_res[k].next_interval = hint[7:0];
          tick_res[k].last = (k == tick_res.size() - 1);
          expected_results.push_back(tick_res[k]);
        end
      end
      REQ_READ: begin
        res.last = 1'b1;
        if (r.handle != '0) res.remaining = pm_count[s][31:0];
        expected_results.push_back(res);
      end
      REQ_STOP: begin
        if (r.handle != '0 && pm_in_use[s]) begin
          cur = pm_active_head;
          prv = NO_SLOT;
          steps = 0;
          while (cur != NO_SLOT && int'(cur) != s && steps < NUM_TIMERS) begin
            prv = cur;
            cur = pm_link[cur];
            steps++;
          end
          if (int'(cur) == s) free_slot(s, prv);
        end
      end
      REQ_SET: if (r.handle != '0) begin
        pm_reload[s] = r.ticks;
        pm_count[s] = longint'(r.ticks);
      end
      REQ_RELOAD: if (r.handle != '0) pm_count[s] = longint'(pm_reload[s]);
      REQ_PAUSE: if (r.handle != '0) pm_paused[s] = r.pause;
      default: ;
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) predict_request(drv_req);
      if (!(in_tvalid && !in_tready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_in) begin
          drv_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= drv_req.req;
          in_tdata <= {1'b0, drv_req.elapsed, drv_req.pause, drv_req.periodic,
                       drv_req.ticks, drv_req.receiver, drv_req.message, drv_req.handle};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    timer_res_t act, exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        act.reply_handle  = out_tdata[13:0];
        act.remaining     = out_tdata[45:14];
        act.exp_valid     = out_tuser;
        act.exp_handle    = out_tdata[59:46];
        act.exp_message   = out_tdata[75:60];
        act.exp_receiver  = out_tdata[91:76];
        act.next_interval = out_tdata[99:92];
        act.last          = out_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, act);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act.reply_handle != exp_r.reply_handle)
            $display("%0t: reply_handle exp %0d act %0d", $time, exp_r.reply_handle,
                     act.reply_handle);
          if (act.remaining != exp_r.remaining)
            $display("%0t: remaining_ticks exp %0d act %0d", $time,
                     $signed(exp_r.remaining), $signed(act.remaining));
          if (act.exp_valid != exp_r.exp_valid)
            $display("%0t: expiry_valid exp %0d act %0d", $time, exp_r.exp_valid,
                     act.exp_valid);
          if (act.exp_handle != exp_r.exp_handle)
            $display("%0t: expiry_handle exp %0d act %0d", $time, exp_r.exp_handle,
                     act.exp_handle);
          if (act.exp_message != exp_r.exp_message)
            $display("%0t: expiry_message exp %0h act %0h", $time, exp_r.exp_message,
                     act.exp_message);
          if (act.exp_receiver != exp_r.exp_receiver)
            $display("%0t: expiry_receiver exp %0h act %0h", $time, exp_r.exp_receiver,
                     act.exp_receiver);
          if (act.next_interval != exp_r.next_interval)
            $display("%0t: next_interval exp %0d act %0d", $time, exp_r.next_interval,
                     act.next_interval);
          if (act.last != exp_r.last)
            $display("%0t: last exp %0d act %0d", $time, exp_r.last, act.last);
          if (act != exp_r) errors++;
        end
      end
      out_tready <= ($urandom_range(99) >= idle_out);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic timer_req_t make_req(logic [REQ_W-1:0] rq, logic [HANDLE_W-1:0] h);
    timer_req_t r;
    r.req = rq;
    r.handle = h;
    r.message = 16'($urandom);
    r.receiver = 16'($urandom);
    r.ticks = TICKS_W'($urandom_range(0, 300));
    r.periodic = 1'($urandom);
    r.pause = 1'($urandom);
    r.elapsed = 8'($urandom_range(1, 40));
    return r;
  endfunction

  // random request, mostly aimed at live timers
  function automatic timer_req_t random_req(int start_bias);
    timer_req_t r;
    int live[$];
    int s, pick;
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i < NUM_TIMERS; i++) if (pm_in_use[i]) live.push_back(i);
    pick = $urandom_range(99);
    if (live.size() > 0 && pick < 80) begin
      s = live[$urandom_range(live.size() - 1)];
      h = slot_handle(s);
      if ($urandom_range(9) == 0) h = HANDLE_W'({8'($urandom_range(1, 255)), SLOT_W'(s)});
    end else if (pick < 90) begin
      h = HANDLE_W'($urandom);
    end else begin
      h = '0;
    end
    pick = $urandom_range(99);
    if (pick < start_bias) r = make_req(REQ_START, h);
    else if (pick < start_bias + 8) r = make_req(REQ_STOP, h);
    else if (pick < start_bias + 14) r = make_req(REQ_SET, h);
    else if (pick < start_bias + 19) r = make_req(REQ_RELOAD, h);
    else if (pick < start_bias + 25) r = make_req(REQ_PAUSE, h);
    else if (pick < start_bias + 33) r = make_req(REQ_READ, h);
    else r = make_req(REQ_TICK, h);
    case ($urandom_range(9))
      0: r.ticks = TICKS_W'($urandom);
      1: r.ticks = '0;
      2: r.elapsed = 8'($urandom_range(1, 255));
      default: ;
    endcase
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_max_interval(logic [7:0] v);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pm_max_interval = v;
  endtask

  task automatic run_random(int n_items, int start_bias);
    for (int i = 0; i < n_items; i += 4) begin
      for (int j = 0; j < 4; j++) pending_reqs.push_back(random_req(start_bias));
      while (pending_reqs.size() > 0) @(posedge clk);
    end
  endtask

  // stimulus sequencing
  initial begin
    timer_req_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    errors = 0;
    cycle_cnt = 0;
    idle_in = 25;
    idle_out = 88;
    drv_req = '0;
    pool_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every request kind and the corner cases
    r = make_req(REQ_START, '0);
    r.message = 16'hFFFF; r.receiver = 16'hFFFF; r.ticks = '1; r.periodic = 1;
    pending_reqs.push_back(r);                                   // handle 64+0
    r = make_req(REQ_START, '0);
    r.message = '0; r.receiver = '0; r.ticks = TICKS_W'(3); r.periodic = 0;
    pending_reqs.push_back(r);                                   // slot 1
    r = make_req(REQ_START, '0);
    r.ticks = TICKS_W'(5); r.periodic = 1;
    pending_reqs.push_back(r);                                   // slot 2
    pending_reqs.push_back(make_req(REQ_READ, HANDLE_W'(64)));
    pending_reqs.push_back(make_req(REQ_READ, '0));              // handle zero read
    r = make_req(REQ_TICK, '0); r.elapsed = 8'd0;                // nothing lowered
    pending_reqs.push_back(r);
    r = make_req(REQ_TICK, '0); r.elapsed = 8'd255;              // expiries, freeing
    pending_reqs.push_back(r);
    r = make_req(REQ_PAUSE, HANDLE_W'(66)); r.pause = 1;
    pending_reqs.push_back(r);
    r = make_req(REQ_TICK, '0); r.elapsed = 8'd200;
    pending_reqs.push_back(r);
    r = make_req(REQ_PAUSE, HANDLE_W'(66)); r.pause = 0;
    pending_reqs.push_back(r);
    r = make_req(REQ_SET, HANDLE_W'(66)); r.ticks = '0;
    pending_reqs.push_back(r);
    r = make_req(REQ_TICK, '0); r.elapsed = 8'd0;                // zero count expires
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(REQ_RELOAD, HANDLE_W'(66)));
    r = make_req(REQ_SET, HANDLE_W'(5)); r.ticks = TICKS_W'(9);  // set on a free slot
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(REQ_READ, HANDLE_W'(16383)));
    pending_reqs.push_back(make_req(REQ_STOP, HANDLE_W'(1)));    // stop of a free slot
    pending_reqs.push_back(make_req(REQ_STOP, '0));              // ignored
    pending_reqs.push_back(make_req(REQ_STOP, HANDLE_W'(64)));   // stop the long timer
    r = make_req(3'd7, HANDLE_W'(66));                           // unknown request
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(REQ_READ, HANDLE_W'(66)));
    r = make_req(REQ_TICK, '0); r.elapsed = 8'd1;
    pending_reqs.push_back(r);
    wait_drained();

    // phase one: sender idles a quarter of the time, receiver mostly stalls
    write_max_interval(8'd255);
    run_random(60, 80);                                          // fill the pool
    run_random(60, 20);
    wait_drained();

    // phase two: roles swapped
    write_max_interval(8'd1);
    idle_in = 88;
    idle_out = 25;
    run_random(120, 22);
    wait_drained();

    // phase three: no idling
    write_max_interval(8'($urandom_range(2, 254)));
    idle_in = 0;
    idle_out = 0;
    run_random(120, 22);
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/stp_pkg.sv
hdl/stp_front.sv
hdl/stp_queue.sv
hdl/stp_back.sv
hdl/software_timer_pool.sv
tb/software_timer_pool_tb.sv
